[design/grc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the sine function for the grid ray caster.
// Used by grc_div, grc_map and grid_ray_caster; depends on nothing.
package grc_pkg;

   localparam int MAP_COLS_DEF = 16;
   localparam int MAP_ROWS_DEF = 16;
   localparam int NUM_RAYS_DEF = 1024;

   localparam int REQ_W = 64;
   localparam int RSP_W = 32;
   localparam int DIV_W = 40;
   localparam int DIV_CNT_W = 6;
   localparam int TRIG_W = 17;

   localparam logic [7:0]  TILE_SIZE_RST   = 8'd100;
   localparam logic [10:0] HALF_FOV_RST    = 11'd683;
   localparam logic [11:0] DELTA_ANGLE_RST = 12'd5;
   localparam logic [7:0]  MAX_STEPS_RST   = 8'd16;
   localparam logic [31:0] PROJ_COEFF_RST  = 32'd77942;

   localparam logic [2:0] REG_TILE_SIZE   = 3'd0;
   localparam logic [2:0] REG_HALF_FOV    = 3'd1;
   localparam logic [2:0] REG_DELTA_ANGLE = 3'd2;
   localparam logic [2:0] REG_MAX_STEPS   = 3'd3;
   localparam logic [2:0] REG_PROJ_COEFF  = 3'd4;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // quarter-wave sine, Q1.15, every 64 binary-angle units
   localparam logic [14:0] QUARTER_SINE [0:16] = '{
      15'd0, 15'd3212, 15'd6393, 15'd9512, 15'd12539, 15'd15446, 15'd18204,
      15'd20787, 15'd23170, 15'd25329, 15'd27245, 15'd28898, 15'd30273,
      15'd31356, 15'd32137, 15'd32609, 15'd32767
   };

   function automatic logic signed [TRIG_W-1:0] sin_q15(input logic [11:0] ang);
      logic [10:0] q;
      logic [4:0]  idx;
      logic [5:0]  fr;
      logic [14:0] lo;
      logic [14:0] hi;
      logic [20:0] step;
      logic [15:0] mag;
      q = ang[10] ? (11'd1024 - {1'b0, ang[9:0]}) : {1'b0, ang[9:0]};
      idx = q[10:6];
      fr = q[5:0];
      lo = 15'd0;
      hi = 15'd0;
      step = 21'd0;
      if (idx >= 5'd16) begin
         mag = 16'd32767;
      end else begin
         lo = QUARTER_SINE[idx];
         hi = QUARTER_SINE[idx + 5'd1];
         step = 21'(hi - lo) * 21'(fr) + 21'd32;
         mag = 16'(lo) + 16'(step[20:6]);
      end
      return ang[11] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

[design/grc_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for widths and the request/response structs.
module grc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  grc_pkg::div_req_type  div_req,
   output grc_pkg::div_rsp_type  div_rsp
);

   localparam int W = grc_pkg::DIV_W;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [grc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]                   rem_ff, rem_in;
   logic [W-1:0]                   quo_ff, quo_in;
   logic [W-1:0]                   dvs_ff, dvs_in;
   logic [W:0]                     shifted;
   logic [W:0]                     trial;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = grc_pkg::DIV_CNT_W'(W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         if (cnt_ff == grc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[design/grc_map.sv]
`timescale 1ns / 1ps
// Wall map: one bit per cell, synchronous read, cleared by a sweep after reset.
// Takes its default size from grc_pkg; sized by the top level.
module grc_map #(
   parameter int DEPTH = grc_pkg::MAP_COLS_DEF * grc_pkg::MAP_ROWS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          ready
);

   logic          wall_mem [DEPTH];
   logic          rd_data_ff;
   logic          clr_active_ff, clr_active_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) clr_active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         wall_mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         wall_mem[wr_addr] <= wr_data;
      end
      if (rd_en) rd_data_ff <= wall_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_active_ff;

endmodule

[design/grid_ray_caster.sv]
`timescale 1ns / 1ps
// Grid ray caster top level. A map-write word is written to the map as it is accepted. A cast
// word gives its result after trying up to max_steps grid lines on each of two passes; the
// 40-bit serial divider sets its time: up to three divisions per ray, and per line one, plus
// one more for a line whose crossing stays in the map. One word in flight; the result register
// lets the next word in while a result waits. Synchronous reset: the map is swept clear
// cell by cell, req_tready low meanwhile.
module grid_ray_caster #(
   parameter int MAP_COLS = grc_pkg::MAP_COLS_DEF,
   parameter int MAP_ROWS = grc_pkg::MAP_ROWS_DEF,
   parameter int NUM_RAYS = grc_pkg::NUM_RAYS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // cell_col[3:0] cell_row[7:4] wall_bit[8] pos_x[24:9] pos_y[40:25]
   // view_angle[52:41] ray_number[62:53], zero pad
   input  logic [grc_pkg::REQ_W-1:0] req_tdata,
   // op: 0 map write, 1 cast
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // ray_id[9:0] wall_height[25:10], zero pad
   output logic [grc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   typedef enum logic [21:0] {
      S_IDLE    = 22'h000001,
      S_ANGLE   = 22'h000002,
      S_SIN     = 22'h000004,
      S_COS     = 22'h000008,
      S_DIVX    = 22'h000010,
      S_DIVY    = 22'h000020,
      S_INIT    = 22'h000040,
      S_DEPTH   = 22'h000080,
      S_DIVW    = 22'h000100,
      S_MULLO   = 22'h000200,
      S_MULHI   = 22'h000400,
      S_CROSS   = 22'h000800,
      S_READ    = 22'h001000,
      S_HIT     = 22'h002000,
      S_STEP    = 22'h004000,
      S_PASSEND = 22'h008000,
      S_FISH    = 22'h010000,
      S_CLO     = 22'h020000,
      S_CHI     = 22'h040000,
      S_CORR    = 22'h080000,
      S_SAT     = 22'h100000,
      S_OUT     = 22'h200000
   } state_type;

   // ---- configuration registers ----
   logic [7:0]  tile_size_ff;
   logic [10:0] half_fov_ff;
   logic [11:0] delta_angle_ff;
   logic [7:0]  max_steps_ff;
   logic [31:0] proj_coeff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff   <= grc_pkg::TILE_SIZE_RST;
         half_fov_ff    <= grc_pkg::HALF_FOV_RST;
         delta_angle_ff <= grc_pkg::DELTA_ANGLE_RST;
         max_steps_ff   <= grc_pkg::MAX_STEPS_RST;
         proj_coeff_ff  <= grc_pkg::PROJ_COEFF_RST;
      end else if (csr_we) begin
         case (csr_index)
            grc_pkg::REG_TILE_SIZE:   tile_size_ff   <= csr_wdata[7:0];
            grc_pkg::REG_HALF_FOV:    half_fov_ff    <= csr_wdata[10:0];
            grc_pkg::REG_DELTA_ANGLE: delta_angle_ff <= csr_wdata[11:0];
            grc_pkg::REG_MAX_STEPS:   max_steps_ff   <= csr_wdata[7:0];
            grc_pkg::REG_PROJ_COEFF:  proj_coeff_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- input word fields ----
   logic [3:0]  req_col, req_row;
   logic        req_wall;
   logic [15:0] req_px, req_py;
   logic [11:0] req_view;
   logic [9:0]  req_ray;

   assign req_col  = req_tdata[3:0];
   assign req_row  = req_tdata[7:4];
   assign req_wall = req_tdata[8];
   assign req_px   = req_tdata[24:9];
   assign req_py   = req_tdata[40:25];
   assign req_view = req_tdata[52:41];
   assign req_ray  = req_tdata[62:53];

   // ---- state ----
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;       // where the divider wait hands back to
   logic      pass_ff, pass_in;     // 0 vertical lines, 1 horizontal lines
   logic [7:0] cnt_ff, cnt_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [15:0] px_ff, px_in, py_ff, py_in;
   logic [11:0] view_ff, view_in;
   logic [9:0]  ray_ff, ray_in;
   logic [11:0] rd_ff, rd_in;       // ray_number * delta_angle, mod one turn
   logic [11:0] ang_ff, ang_in;
   logic signed [grc_pkg::TRIG_W-1:0] s_ff, s_in, c_ff, c_in;
   logic [11:0] q0x_ff, q0x_in, q0y_ff, q0y_in;
   logic signed [13:0] k_ff, k_in;  // current grid line, in cells
   logic [39:0] depth_ff, depth_in;
   logic [39:0] dv_ff, dv_in;
   logic [54:0] prod_ff, prod_in;
   logic [7:0]  line_idx_ff, line_idx_in;
   logic [14:0] cd_ff, cd_in;
   logic [15:0] h_ff, h_in;
   logic [9:0]  rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_h_ff, rsp_h_in;

   // ---- submodules ----
   grc_pkg::div_req_type div_req;
   grc_pkg::div_rsp_type div_rsp;

   grc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic              map_wr_en, map_rd_en, map_rd_data, map_ready;
   logic [MAP_AW-1:0] map_wr_addr, map_rd_addr;
   logic [16:0]       wr_addr_full, rd_addr_full;

   grc_map #(.DEPTH(MAP_DEPTH), .AW(MAP_AW)) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (req_wall),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .ready   (map_ready)
   );

   // ---- datapath ----
   logic [7:0]  t_eff, steps_eff;
   logic signed [grc_pkg::TRIG_W-1:0] prim, sec, prim_neg, sec_neg, sin_val;
   logic        prim_pos;
   logic [14:0] abs_prim, abs_sec;
   logic [15:0] orig, orig2;
   logic [11:0] q0;
   logic [11:0] trig_ang;
   logic [21:0] rd_prod;
   logic signed [22:0] line_val;
   logic signed [26:0] d_val;
   logic [26:0] d_mag;
   logic [19:0] mul_a;
   logic [14:0] mul_b;
   logic [34:0] mul_p;
   logic [39:0] m_val;
   logic [41:0] v_val, v_abs;
   logic [37:0] a_val;
   logic [16:0] cross_lim;
   logic [8:0]  line_cells;
   logic signed [14:0] k_ext, li;
   logic        cross_ok, line_ok;
   logic [7:0]  cross_idx, cell_col, cell_row;
   logic [39:0] corr;
   logic        accept, out_load;

   assign t_eff     = (tile_size_ff == 8'd0) ? 8'd1 : tile_size_ff;
   assign steps_eff = (max_steps_ff == 8'd0) ? 8'd1 : max_steps_ff;

   // pass 0 walks x lines driven by cos; pass 1 walks y lines driven by sin
   assign prim     = pass_ff ? s_ff : c_ff;
   assign sec      = pass_ff ? c_ff : s_ff;
   assign prim_neg = -prim;
   assign sec_neg  = -sec;
   assign prim_pos = !prim[grc_pkg::TRIG_W-1];
   assign abs_prim = prim[grc_pkg::TRIG_W-1] ? prim_neg[14:0] : prim[14:0];
   assign abs_sec  = sec[grc_pkg::TRIG_W-1] ? sec_neg[14:0] : sec[14:0];
   assign orig     = pass_ff ? py_ff : px_ff;
   assign orig2    = pass_ff ? px_ff : py_ff;
   assign q0       = pass_ff ? q0y_ff : q0x_ff;

   assign rd_prod = ray_ff * delta_angle_ff;

   // one sine unit, shared by ray sine, ray cosine and fisheye cosine
   always_comb begin
      case (state_ff)
         S_SIN:   trig_ang = ang_ff;
         S_COS:   trig_ang = ang_ff + 12'd1024;
         default: trig_ang = 12'(half_fov_ff) - rd_ff + 12'd1024;
      endcase
   end
   assign sin_val = grc_pkg::sin_q15(trig_ang);

   // depth numerator: |line * 16 - origin|
   assign line_val = k_ff * $signed({1'b0, t_eff});
   assign d_val    = $signed({line_val, 4'b0000}) - $signed(27'(orig));
   assign d_mag    = d_val[26] ? 27'(-d_val) : 27'(d_val);

   // shared 20x15 multiplier, two halves per product
   always_comb begin
      case (state_ff)
         S_MULLO: mul_a = div_rsp.quotient[19:0];
         S_CLO:   mul_a = depth_ff[19:0];
         default: mul_a = depth_ff[39:20];
      endcase
   end
   assign mul_b = (state_ff == S_CLO || state_ff == S_CHI) ? cd_ff : abs_sec;
   assign mul_p = mul_a * mul_b;

   // crossing on the other axis, Q.4 truncated toward zero
   assign m_val = prod_ff[54:15];
   assign v_val = sec[grc_pkg::TRIG_W-1] ? (42'(orig2) - 42'(m_val))
                                         : (42'(orig2) + 42'(m_val));
   assign v_abs = v_val[41] ? -v_val : v_val;
   assign a_val = v_abs[41:4];
   assign cross_lim = pass_ff ? (17'(MAP_COLS) * 17'(t_eff)) : (17'(MAP_ROWS) * 17'(t_eff));
   assign cross_ok  = !(v_val[41] && a_val != 38'd0) && (a_val < 38'(cross_lim));

   // cell beyond the line: forward of it going positive (one further at tile size 1), behind it going negative
   assign k_ext      = {k_ff[13], k_ff};
   assign li         = prim_pos ? ((t_eff == 8'd1) ? k_ext + 15'sd1 : k_ext) : k_ext - 15'sd1;
   assign line_cells = pass_ff ? 9'(MAP_ROWS) : 9'(MAP_COLS);
   assign line_ok    = !li[14] && (li[13:0] < 14'(line_cells));

   assign cross_idx = div_rsp.quotient[7:0];
   assign cell_col  = pass_ff ? cross_idx : line_idx_ff;
   assign cell_row  = pass_ff ? line_idx_ff : cross_idx;
   assign rd_addr_full = 17'(cell_row) * 17'(MAP_COLS) + 17'(cell_col);
   assign map_rd_addr  = rd_addr_full[MAP_AW-1:0];

   assign corr = prod_ff[54:15];

   assign req_tready = (state_ff == S_IDLE) && map_ready;
   assign accept     = req_tvalid && req_tready;

   assign wr_addr_full = 17'(req_row) * 17'(MAP_COLS) + 17'(req_col);
   assign map_wr_addr  = wr_addr_full[MAP_AW-1:0];
   assign map_wr_en    = accept && !req_tuser
                         && (32'(req_col) < MAP_COLS) && (32'(req_row) < MAP_ROWS);

   // ---- sequencer ----
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      pass_in     = pass_ff;
      cnt_in      = cnt_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      view_in     = view_ff;
      ray_in      = ray_ff;
      rd_in       = rd_ff;
      ang_in      = ang_ff;
      s_in        = s_ff;
      c_in        = c_ff;
      q0x_in      = q0x_ff;
      q0y_in      = q0y_ff;
      k_in        = k_ff;
      depth_in    = depth_ff;
      dv_in       = dv_ff;
      prod_in     = prod_ff;
      line_idx_in = line_idx_ff;
      cd_in       = cd_ff;
      h_in        = h_ff;
      map_rd_en   = 1'b0;
      out_load    = 1'b0;
      div_req     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser && (32'(req_ray) < NUM_RAYS)) begin
               px_in    = req_px;
               py_in    = req_py;
               view_in  = req_view;
               ray_in   = req_ray;
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            rd_in    = rd_prod[11:0];
            ang_in   = view_ff - 12'(half_fov_ff) + rd_prod[11:0];
            state_in = S_SIN;
         end
         S_SIN: begin
            s_in     = (sin_val == '0) ? grc_pkg::TRIG_W'(1) : sin_val;
            state_in = S_COS;
         end
         S_COS: begin
            c_in     = (sin_val == '0) ? grc_pkg::TRIG_W'(1) : sin_val;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            div_req.start    = 1'b1;
            div_req.dividend = grc_pkg::DIV_W'(px_ff[15:4]);
            div_req.divisor  = grc_pkg::DIV_W'(t_eff);
            ret_in           = S_DIVY;
            state_in         = S_DIVW;
         end
         S_DIVY: begin
            q0x_in           = div_rsp.quotient[11:0];
            div_req.start    = 1'b1;
            div_req.dividend = grc_pkg::DIV_W'(py_ff[15:4]);
            div_req.divisor  = grc_pkg::DIV_W'(t_eff);
            pass_in          = 1'b0;
            ret_in           = S_INIT;
            state_in         = S_DIVW;
         end
         S_INIT: begin
            if (!pass_ff && ret_ff == S_INIT) q0y_in = div_rsp.quotient[11:0];
            k_in     = $signed(14'(q0)) + (prim_pos ? 14'sd1 : 14'sd0);
            cnt_in   = 8'd0;
            state_in = S_DEPTH;
         end
         S_DEPTH: begin
            div_req.start    = 1'b1;
            div_req.dividend = {d_mag[24:0], 15'b0};
            div_req.divisor  = grc_pkg::DIV_W'(abs_prim);
            ret_in           = S_MULLO;
            state_in         = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) state_in = ret_ff;
         end
         S_MULLO: begin
            depth_in = div_rsp.quotient;
            prod_in  = 55'(mul_p);
            state_in = S_MULHI;
         end
         S_MULHI: begin
            prod_in  = prod_ff + {mul_p, 20'b0};
            state_in = S_CROSS;
         end
         S_CROSS: begin
            if (line_ok && cross_ok) begin
               line_idx_in      = li[7:0];
               div_req.start    = 1'b1;
               div_req.dividend = grc_pkg::DIV_W'(a_val[15:0]);
               div_req.divisor  = grc_pkg::DIV_W'(t_eff);
               ret_in           = S_READ;
               state_in         = S_DIVW;
            end else begin
               state_in = S_STEP;
            end
         end
         S_READ: begin
            map_rd_en = 1'b1;
            state_in  = S_HIT;
         end
         S_HIT: begin
            state_in = map_rd_data ? S_PASSEND : S_STEP;
         end
         S_STEP: begin
            if ({1'b0, cnt_ff} + 9'd1 == {1'b0, steps_eff}) begin
               state_in = S_PASSEND;
            end else begin
               cnt_in   = cnt_ff + 8'd1;
               k_in     = prim_pos ? k_ff + 14'sd1 : k_ff - 14'sd1;
               state_in = S_DEPTH;
            end
         end
         S_PASSEND: begin
            if (!pass_ff) begin
               dv_in    = depth_ff;
               pass_in  = 1'b1;
               state_in = S_INIT;
            end else begin
               state_in = S_FISH;
            end
         end
         S_FISH: begin
            // equal depths keep the horizontal one
            depth_in = (dv_ff < depth_ff) ? dv_ff : depth_ff;
            if (sin_val[grc_pkg::TRIG_W-1]) begin
               h_in     = 16'd0;
               state_in = S_OUT;
            end else begin
               cd_in    = sin_val[14:0];
               state_in = S_CLO;
            end
         end
         S_CLO: begin
            prod_in  = 55'(mul_p);
            state_in = S_CHI;
         end
         S_CHI: begin
            prod_in  = prod_ff + {mul_p, 20'b0};
            state_in = S_CORR;
         end
         S_CORR: begin
            if (corr == 40'd0) begin
               h_in     = 16'hFFFF;
               state_in = S_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = grc_pkg::DIV_W'({proj_coeff_ff, 4'b0000});
               div_req.divisor  = corr;
               ret_in           = S_SAT;
               state_in         = S_DIVW;
            end
         end
         S_SAT: begin
            h_in     = (div_rsp.quotient[39:16] != 24'd0) ? 16'hFFFF : div_rsp.quotient[15:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_id_in    = out_load ? ray_ff : rsp_id_ff;
   assign rsp_h_in     = out_load ? h_ff : rsp_h_ff;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         pass_ff      <= 1'b0;
         cnt_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      view_ff     <= view_in;
      ray_ff      <= ray_in;
      rd_ff       <= rd_in;
      ang_ff      <= ang_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      q0x_ff      <= q0x_in;
      q0y_ff      <= q0y_in;
      k_ff        <= k_in;
      depth_ff    <= depth_in;
      dv_ff       <= dv_in;
      prod_ff     <= prod_in;
      line_idx_ff <= line_idx_in;
      cd_ff       <= cd_in;
      h_ff        <= h_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_h_ff    <= rsp_h_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_h_ff, rsp_id_ff};

   // ---- checks ----
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIVW)
      else $error("divider result arrived outside the wait state");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("result not presented after load");

endmodule
